// ===== src/mfek_pkg.sv =====
// Package for the Edmonds-Karp max-flow block: sizes, command codes, state codes
// and the request type of the shared adder. Depends on nothing.
package mfek_pkg;

  localparam int MAX_NODES  = 16;
  localparam int NODE_BITS  = 4;
  localparam int ADDR_BITS  = 2 * NODE_BITS;
  localparam int CAP_BITS   = 16;
  localparam int FLOW_BITS  = CAP_BITS + 1;
  localparam int RES_BITS   = CAP_BITS + 2;
  localparam int TOTAL_BITS = 20;
  localparam int ALU_BITS   = TOTAL_BITS + 1;
  localparam int NC_BITS    = 5;
  localparam int QPTR_BITS  = NODE_BITS + 1;

  localparam logic [NC_BITS-1:0]    NC_RESET  = NC_BITS'(MAX_NODES);
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
  localparam logic signed [ALU_BITS-1:0] FLOW_MIN = -(ALU_BITS'(1) <<< CAP_BITS);

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  typedef enum logic [12:0] {
    ST_CLEAR    = 13'b0000000000001,
    ST_IDLE     = 13'b0000000000010,
    ST_READ     = 13'b0000000000100,
    ST_BFS_INIT = 13'b0000000001000,
    ST_POP      = 13'b0000000010000,
    ST_SCAN_A   = 13'b0000000100000,
    ST_SCAN_E   = 13'b0000001000000,
    ST_BN_A     = 13'b0000010000000,
    ST_BN_E     = 13'b0000100000000,
    ST_UP_A     = 13'b0001000000000,
    ST_UP_F     = 13'b0010000000000,
    ST_UP_R     = 13'b0100000000000,
    ST_DONE     = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic                       sub;
    logic signed [ALU_BITS-1:0] a;
    logic signed [ALU_BITS-1:0] b;
  } alu_req_t;

endpackage

// ===== src/mfek_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mfek_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mfek_alu.sv =====
// Shared add/subtract unit of the max-flow sequencer.
// Depends on mfek_pkg.
module mfek_alu (
  input  mfek_pkg::alu_req_t                    req,
  output logic signed [mfek_pkg::ALU_BITS-1:0] sum
);

  assign sum = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

// ===== src/max_flow_edmonds_karp.sv =====
// Edmonds-Karp maximum flow over a 16x16 capacity matrix; uses mfek_pkg, mfek_ram, mfek_alu.
// After reset a clearing pass zeroes both matrices; no request is taken meanwhile.
// A load request is written from idle directly; a read request goes through ST_READ, plus the output handoff.
// A run request passes SCAN_A, SCAN_E per (popped node, neighbor) pair of each search, then
// per path edge BN_A, BN_E for the bottleneck and UP_A, UP_F, UP_R for the update, per path.
// One request is in flight at a time; the single matrix read port and the shared adder set it.
module max_flow_edmonds_karp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_cmd,
  input  logic [mfek_pkg::NODE_BITS-1:0]        in_from_node,
  input  logic [mfek_pkg::NODE_BITS-1:0]        in_to_node,
  input  logic [mfek_pkg::CAP_BITS-1:0]         in_capacity,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_result_kind,
  output logic [mfek_pkg::TOTAL_BITS-1:0]       out_max_flow,
  output logic signed [mfek_pkg::FLOW_BITS-1:0] out_flow_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mfek_pkg::NC_BITS-1:0]          cfg_node_count
);

  localparam int NB = mfek_pkg::NODE_BITS;
  localparam int AW = mfek_pkg::ADDR_BITS;
  localparam int FB = mfek_pkg::FLOW_BITS;
  localparam int RB = mfek_pkg::RES_BITS;
  localparam int TB = mfek_pkg::TOTAL_BITS;
  localparam int WB = mfek_pkg::ALU_BITS;
  localparam int QB = mfek_pkg::QPTR_BITS;
  localparam int CB = mfek_pkg::CAP_BITS;

  mfek_pkg::state_t state_r, state_nxt;

  logic [mfek_pkg::NC_BITS-1:0] nc_r, nc_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [mfek_pkg::MAX_NODES-1:0] visited_r, visited_nxt;
  logic [NB-1:0]   parent_r [mfek_pkg::MAX_NODES];
  logic [NB-1:0]   parent_nxt [mfek_pkg::MAX_NODES];
  logic [NB-1:0]   queue_r [mfek_pkg::MAX_NODES];
  logic [NB-1:0]   queue_nxt [mfek_pkg::MAX_NODES];
  logic [QB-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [NB-1:0]   u_r, u_nxt, v_r, v_nxt;
  logic [RB-1:0]   bn_r, bn_nxt;
  logic [TB-1:0]   total_r, total_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic [TB-1:0]   out_max_r, out_max_nxt;
  logic signed [FB-1:0] out_flow_r, out_flow_nxt;

  // Matrix storage: both RAMs share the read and write address.
  logic            cap_we, flow_we;
  logic [AW-1:0]   waddr, raddr;
  logic [CB-1:0]   cap_wdata, cap_rdata;
  logic [FB-1:0]   flow_wdata, flow_rdata;

  mfek_pkg::alu_req_t      alu_req;
  logic signed [WB-1:0]    alu_sum;

  logic [NB-1:0]   sink;
  logic [NB-1:0]   pu;
  logic            res_pos;
  logic            in_fire;

  mfek_ram #(.WIDTH(CB), .DEPTH(mfek_pkg::MAX_NODES * mfek_pkg::MAX_NODES)) u_cap_ram (
    .clk   (clk),
    .we    (cap_we),
    .waddr (waddr),
    .wdata (cap_wdata),
    .raddr (raddr),
    .rdata (cap_rdata)
  );

  mfek_ram #(.WIDTH(FB), .DEPTH(mfek_pkg::MAX_NODES * mfek_pkg::MAX_NODES)) u_flow_ram (
    .clk   (clk),
    .we    (flow_we),
    .waddr (waddr),
    .wdata (flow_wdata),
    .raddr (raddr),
    .rdata (flow_rdata)
  );

  mfek_alu u_alu (
    .req (alu_req),
    .sum (alu_sum)
  );

  // The node count is clamped to 2..16; the sink is the last node in use.
  always_comb begin
    if (nc_r < mfek_pkg::NC_BITS'(2)) begin
      sink = NB'(1);
    end else if (nc_r > mfek_pkg::NC_RESET) begin
      sink = NB'(mfek_pkg::MAX_NODES - 1);
    end else begin
      sink = NB'(nc_r - mfek_pkg::NC_BITS'(1));
    end
  end

  assign pu        = parent_r[v_r];
  assign res_pos   = !alu_sum[WB-1] && (alu_sum != '0);
  assign in_stall  = (state_r != mfek_pkg::ST_IDLE) || out_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_max_flow    = out_max_r;
  assign out_flow_value  = out_flow_r;

  always_comb begin
    state_nxt     = state_r;
    nc_nxt        = nc_r;
    clr_nxt       = clr_r;
    visited_nxt   = visited_r;
    parent_nxt    = parent_r;
    queue_nxt     = queue_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    bn_nxt        = bn_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_max_nxt   = out_max_r;
    out_flow_nxt  = out_flow_r;
    cap_we        = 1'b0;
    flow_we       = 1'b0;
    waddr         = '0;
    raddr         = '0;
    cap_wdata     = '0;
    flow_wdata    = '0;
    alu_req.sub   = 1'b0;
    alu_req.a     = '0;
    alu_req.b     = '0;

    if (cfg_valid) begin
      nc_nxt = cfg_node_count;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mfek_pkg::ST_CLEAR: begin
        // Zero one entry of both matrices per cycle.
        cap_we  = 1'b1;
        flow_we = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = mfek_pkg::ST_IDLE;
        end
      end
      mfek_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            mfek_pkg::CMD_LOAD: begin
              cap_we    = 1'b1;
              flow_we   = 1'b1;
              waddr     = {in_from_node, in_to_node};
              cap_wdata = in_capacity;
            end
            mfek_pkg::CMD_RUN: begin
              total_nxt = '0;
              state_nxt = mfek_pkg::ST_BFS_INIT;
            end
            mfek_pkg::CMD_READ: begin
              raddr     = {in_from_node, in_to_node};
              state_nxt = mfek_pkg::ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      mfek_pkg::ST_READ: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = 1'b1;
        out_max_nxt   = '0;
        out_flow_nxt  = flow_rdata;
        state_nxt     = mfek_pkg::ST_IDLE;
      end
      mfek_pkg::ST_BFS_INIT: begin
        visited_nxt    = '0;
        visited_nxt[0] = 1'b1;
        queue_nxt[0]   = '0;
        parent_nxt[0]  = '0;
        head_nxt       = '0;
        tail_nxt       = QB'(1);
        state_nxt      = mfek_pkg::ST_POP;
      end
      mfek_pkg::ST_POP: begin
        if (head_r == tail_r) begin
          if (visited_r[sink]) begin
            v_nxt     = sink;
            bn_nxt    = '1;
            state_nxt = mfek_pkg::ST_BN_A;
          end else begin
            state_nxt = mfek_pkg::ST_DONE;
          end
        end else begin
          u_nxt     = queue_r[head_r[NB-1:0]];
          head_nxt  = head_r + QB'(1);
          v_nxt     = '0;
          state_nxt = mfek_pkg::ST_SCAN_A;
        end
      end
      mfek_pkg::ST_SCAN_A: begin
        raddr     = {u_r, v_r};
        state_nxt = mfek_pkg::ST_SCAN_E;
      end
      mfek_pkg::ST_SCAN_E: begin
        // Residual capacity of the edge from the popped node to v.
        alu_req.sub = 1'b1;
        alu_req.a   = WB'(cap_rdata);
        alu_req.b   = WB'($signed(flow_rdata));
        if (res_pos && !visited_r[v_r]) begin
          visited_nxt[v_r] = 1'b1;
          parent_nxt[v_r]  = u_r;
          if (tail_r < QB'(mfek_pkg::MAX_NODES)) begin
            queue_nxt[tail_r[NB-1:0]] = v_r;
            tail_nxt                  = tail_r + QB'(1);
          end
        end
        if (v_r == sink) begin
          state_nxt = mfek_pkg::ST_POP;
        end else begin
          v_nxt     = v_r + NB'(1);
          state_nxt = mfek_pkg::ST_SCAN_A;
        end
      end
      mfek_pkg::ST_BN_A: begin
        raddr     = {pu, v_r};
        state_nxt = mfek_pkg::ST_BN_E;
      end
      mfek_pkg::ST_BN_E: begin
        alu_req.sub = 1'b1;
        alu_req.a   = WB'(cap_rdata);
        alu_req.b   = WB'($signed(flow_rdata));
        if (alu_sum[RB-1:0] < bn_r) begin
          bn_nxt = alu_sum[RB-1:0];
        end
        if (pu == '0) begin
          v_nxt     = sink;
          state_nxt = mfek_pkg::ST_UP_A;
        end else begin
          v_nxt     = pu;
          state_nxt = mfek_pkg::ST_BN_A;
        end
      end
      mfek_pkg::ST_UP_A: begin
        raddr = {pu, v_r};
        // The adder is free here, so the run total is advanced on the first edge.
        if (v_r == sink) begin
          alu_req.a = WB'(total_r);
          alu_req.b = WB'(bn_r);
          if (alu_sum > $signed(WB'(mfek_pkg::TOTAL_MAX))) begin
            total_nxt = mfek_pkg::TOTAL_MAX;
          end else begin
            total_nxt = alu_sum[TB-1:0];
          end
        end
        state_nxt = mfek_pkg::ST_UP_F;
      end
      mfek_pkg::ST_UP_F: begin
        alu_req.a  = WB'($signed(flow_rdata));
        alu_req.b  = WB'(bn_r);
        flow_we    = 1'b1;
        waddr      = {pu, v_r};
        flow_wdata = alu_sum[FB-1:0];
        raddr      = {v_r, pu};
        state_nxt  = mfek_pkg::ST_UP_R;
      end
      mfek_pkg::ST_UP_R: begin
        // Reverse entry drops by the bottleneck and saturates at the lowest flow.
        alu_req.sub = 1'b1;
        alu_req.a   = WB'($signed(flow_rdata));
        alu_req.b   = WB'(bn_r);
        flow_we     = 1'b1;
        waddr       = {v_r, pu};
        if (alu_sum < mfek_pkg::FLOW_MIN) begin
          flow_wdata = mfek_pkg::FLOW_MIN[FB-1:0];
        end else begin
          flow_wdata = alu_sum[FB-1:0];
        end
        v_nxt = pu;
        if (pu == '0) begin
          state_nxt = mfek_pkg::ST_BFS_INIT;
        end else begin
          state_nxt = mfek_pkg::ST_UP_A;
        end
      end
      mfek_pkg::ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = 1'b0;
        out_max_nxt   = total_r;
        out_flow_nxt  = '0;
        state_nxt     = mfek_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mfek_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfek_pkg::ST_CLEAR;
      nc_r        <= mfek_pkg::NC_RESET;
      clr_r       <= '0;
      visited_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nc_r        <= nc_nxt;
      clr_r       <= clr_nxt;
      visited_r   <= visited_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    parent_r   <= parent_nxt;
    queue_r    <= queue_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    bn_r       <= bn_nxt;
    total_r    <= total_nxt;
    out_kind_r <= out_kind_nxt;
    out_max_r  <= out_max_nxt;
    out_flow_r <= out_flow_nxt;
  end

`ifndef SYNTHESIS
  // A result appears only when a read or a run finishes.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      ($past(state_r) == mfek_pkg::ST_READ || $past(state_r) == mfek_pkg::ST_DONE))
    else $error("result raised outside read or run completion");

  // The search queue never pops more than it pushed.
  assert property (@(posedge clk) disable iff (!rst_n) head_r <= tail_r)
    else $error("search queue head passed tail");

  // A path walk always starts with the sink reached by the search.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfek_pkg::ST_POP && state_nxt == mfek_pkg::ST_BN_A) |=> visited_r[v_r])
    else $error("bottleneck walk started from an unreached node");

  // The source stays marked throughout a search.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mfek_pkg::ST_SCAN_E || state_r == mfek_pkg::ST_POP) |-> visited_r[0])
    else $error("source lost its visited mark");
`endif

endmodule
